@@ hdl/nmeafs_pkg.sv @@
package nmeafs_pkg;

	// sentence geometry defaults
	localparam int MAX_FIELDS_DEF      = 16;
	localparam int MAX_FIELD_CHARS_DEF = 16;
	localparam int HEADER_CHARS        = 6;
	localparam int HDR_IDX_W           = $clog2(HEADER_CHARS);
	localparam int NUM_KINDS           = 6;

	// counter and kind widths fixed by the result word
	localparam int CNT_W  = 5;
	localparam int KIND_W = 3;

	// special characters
	localparam logic [7:0] CH_NEWLINE = 8'h0a;
	localparam logic [7:0] CH_COMMA   = 8'h2c;
	localparam logic [7:0] CH_STAR    = 8'h2a;
	localparam logic [7:0] CH_DOLLAR  = 8'h24;

	// sentence kind codes
	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd0;
	localparam logic [KIND_W-1:0] KIND_GGA     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_GLL     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_GSV     = 3'd3;
	localparam logic [KIND_W-1:0] KIND_GSA     = 3'd4;
	localparam logic [KIND_W-1:0] KIND_RMC     = 3'd5;
	localparam logic [KIND_W-1:0] KIND_VTG     = 3'd6;

	typedef logic [7:0] hdr_char_t;
	typedef hdr_char_t [HEADER_CHARS-1:0] header_t;

	// known headers, character 0 in the lowest slot
	function automatic header_t kind_header(input int k);
		header_t h;
		h = '0;
		unique case (k)
			0:       h = {"A", "G", "G", "P", "G", "$"};
			1:       h = {"L", "L", "G", "P", "G", "$"};
			2:       h = {"V", "S", "G", "P", "G", "$"};
			3:       h = {"A", "S", "G", "P", "G", "$"};
			4:       h = {"C", "M", "R", "P", "G", "$"};
			default: h = {"G", "T", "V", "P", "G", "$"};
		endcase
		return h;
	endfunction

	// kind code for a table row
	function automatic logic [KIND_W-1:0] kind_code(input int k);
		logic [KIND_W-1:0] c;
		c = KIND_UNKNOWN;
		unique case (k)
			0:       c = KIND_GGA;
			1:       c = KIND_GLL;
			2:       c = KIND_GSV;
			3:       c = KIND_GSA;
			4:       c = KIND_RMC;
			default: c = KIND_VTG;
		endcase
		return c;
	endfunction

endpackage

@@ hdl/nmea_sentence_field_splitter.sv @@
// NMEA 0183 sentence tokenizer. Each accepted word is one received character and
// yields exactly one registered result word: the field and position the
// character belongs to, whether it was kept or dropped, and on a newline the
// sentence kind found by matching the six stored header bytes ($GPGGA, $GPGLL,
// $GPGSV, $GPGSA, $GPRMC, $GPVTG, else unknown). Characters before a '$' are
// ignored; ',' and '*' advance the field; the field counter saturates at
// MAX_FIELDS and positions stop at MAX_FIELD_CHARS. One character is taken
// every cycle: the parser state updates in the accepting cycle and the single
// output register is refilled in the same cycle it is drained, so in_ready only
// drops while a result sits unaccepted at the output.
module nmea_sentence_field_splitter #(
	parameter int MAX_FIELDS      = nmeafs_pkg::MAX_FIELDS_DEF,
	parameter int MAX_FIELD_CHARS = nmeafs_pkg::MAX_FIELD_CHARS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       rx_char,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [nmeafs_pkg::CNT_W-1:0]     field_number,
	output logic [nmeafs_pkg::CNT_W-1:0]     char_position,
	output logic [7:0]                       char_value,
	output logic                             char_stored,
	output logic                             char_dropped,
	output logic                             sentence_end,
	output logic [nmeafs_pkg::KIND_W-1:0]    sentence_kind
);

	localparam logic [nmeafs_pkg::CNT_W-1:0] FIELD_LIM = nmeafs_pkg::CNT_W'(MAX_FIELDS);
	localparam logic [nmeafs_pkg::CNT_W-1:0] POS_LIM   = nmeafs_pkg::CNT_W'(MAX_FIELD_CHARS);
	localparam logic [nmeafs_pkg::CNT_W-1:0] HDR_LIM   =
		nmeafs_pkg::CNT_W'(nmeafs_pkg::HEADER_CHARS);

	// parser state
	logic                          start_q;
	logic [nmeafs_pkg::CNT_W-1:0]  field_q;
	logic [nmeafs_pkg::CNT_W-1:0]  pos_q;
	nmeafs_pkg::header_t           header_q;

	// next state and result
	logic                          accept;
	logic                          start_d;
	logic [nmeafs_pkg::CNT_W-1:0]  field_d;
	logic [nmeafs_pkg::CNT_W-1:0]  pos_d;
	logic [nmeafs_pkg::CNT_W-1:0]  pos_out;
	logic                          stored;
	logic                          dropped;
	logic                          is_nl;
	logic                          is_delim;
	logic [nmeafs_pkg::KIND_W-1:0] kind;
	logic                          hdr_wr;

	assign in_ready = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;
	assign is_nl    = (rx_char == nmeafs_pkg::CH_NEWLINE);
	assign is_delim = (rx_char == nmeafs_pkg::CH_COMMA) || (rx_char == nmeafs_pkg::CH_STAR);

	nmeafs_classify u_classify (
		.header (header_q),
		.kind   (kind)
	);

	// per-character decision
	always_comb begin
		start_d = start_q;
		field_d = field_q;
		pos_d   = pos_q;
		pos_out = pos_q;
		stored  = 1'b0;
		dropped = 1'b0;
		priority if (is_nl) begin
			start_d = 1'b0;
			field_d = '0;
			pos_d   = '0;
			pos_out = '0;
		end else if (start_q && is_delim) begin
			if (field_q < FIELD_LIM) begin
				field_d = field_q + 1'b1;
			end
			pos_d   = '0;
			pos_out = '0;
		end else if (!start_q) begin
			if (rx_char == nmeafs_pkg::CH_DOLLAR) begin
				start_d = 1'b1;
				stored  = 1'b1;
				pos_d   = pos_q + 1'b1;
			end
		end else begin
			if ((field_q < FIELD_LIM) && (pos_q < POS_LIM)) begin
				stored = 1'b1;
				pos_d  = pos_q + 1'b1;
			end else begin
				dropped = 1'b1;
			end
		end
	end

	assign hdr_wr = stored && (field_q == '0) && (pos_q < HDR_LIM);

	// counters and header bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= 1'b0;
			field_q  <= '0;
			pos_q    <= '0;
			header_q <= '0;
		end else if (accept) begin
			start_q <= start_d;
			field_q <= field_d;
			pos_q   <= pos_d;
			if (hdr_wr) begin
				header_q[pos_q[nmeafs_pkg::HDR_IDX_W-1:0]] <= rx_char;
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (accept) begin
			field_number  <= field_d;
			char_position <= pos_out;
			char_value    <= rx_char;
			char_stored   <= stored;
			char_dropped  <= dropped;
			sentence_end  <= is_nl;
			sentence_kind <= is_nl ? kind : nmeafs_pkg::KIND_UNKNOWN;
		end
	end

`ifndef SYNTHESIS
	// field counter saturates at its limit
	a_field_sat: assert property (@(posedge clk) disable iff (!arst_n)
		field_q <= FIELD_LIM)
		else $error("field counter beyond limit");

	// counters sit at zero while no sentence is open
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!start_q |-> (field_q == '0) && (pos_q == '0))
		else $error("counters nonzero outside a sentence");

	// a word is never both stored and dropped
	a_store_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(char_stored && char_dropped))
		else $error("stored and dropped together");

	// a sentence end reports field and position zero
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sentence_end |-> (field_number == '0) && (char_position == '0))
		else $error("sentence end with nonzero counters");

	// a kind is only reported at sentence end
	a_kind_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (sentence_kind != nmeafs_pkg::KIND_UNKNOWN) |-> sentence_end)
		else $error("kind reported outside sentence end");

	// a newline closes the sentence
	a_nl_close: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_nl |=> !start_q)
		else $error("sentence still open after newline");
`endif

endmodule

@@ hdl/nmeafs_classify.sv @@
module nmeafs_classify (
	input  nmeafs_pkg::header_t            header,
	output logic [nmeafs_pkg::KIND_W-1:0]  kind
);

	logic [nmeafs_pkg::NUM_KINDS-1:0] hit;

	// compare against every known header in parallel
	always_comb begin
		for (int k = 0; k < nmeafs_pkg::NUM_KINDS; k++) begin
			hit[k] = (header == nmeafs_pkg::kind_header(k));
		end
	end

	// first matching row wins
	always_comb begin
		kind = nmeafs_pkg::KIND_UNKNOWN;
		for (int k = nmeafs_pkg::NUM_KINDS - 1; k >= 0; k--) begin
			if (hit[k]) begin
				kind = nmeafs_pkg::kind_code(k);
			end
		end
	end

endmodule
